### src/igc_pkg.sv
package igc_pkg;

    localparam int COUNT_WIDTH_DEF = 32;
    localparam int MAX_INPUTS_DEF  = 255;

    localparam logic [63:0] SEED_TAG = 64'h434d454e41544956;
    localparam logic [63:0] GOLDEN   = 64'h9e3779b97f4a7c15;

    // configuration register indexes
    localparam logic [2:0] CFG_ROW_COUNT    = 3'd0;
    localparam logic [2:0] CFG_COLUMNS      = 3'd1;
    localparam logic [2:0] CFG_INPUT_LENGTH = 3'd2;
    localparam logic [2:0] CFG_USE_IDS      = 3'd3;
    localparam logic [2:0] CFG_EMIT_GROUPS  = 3'd4;

    // record kinds
    localparam logic [1:0] KIND_GROUP   = 2'd0;
    localparam logic [1:0] KIND_SUMMARY = 2'd1;
    localparam logic [1:0] KIND_ERROR   = 2'd2;

    // error codes
    localparam logic [1:0] ERR_NONE     = 2'd0;
    localparam logic [1:0] ERR_INTERVAL = 2'd1;
    localparam logic [1:0] ERR_PRODUCT  = 2'd2;
    localparam logic [1:0] ERR_OVERFLOW = 2'd3;

    // hash operand select
    localparam logic [2:0] MIX_ROWS    = 3'd0;
    localparam logic [2:0] MIX_INPUTS  = 3'd1;
    localparam logic [2:0] MIX_IDS     = 3'd2;
    localparam logic [2:0] MIX_LENGTH  = 3'd3;
    localparam logic [2:0] MIX_START   = 3'd4;
    localparam logic [2:0] MIX_END     = 3'd5;
    localparam logic [2:0] MIX_PRODUCT = 3'd6;

    // output record select
    localparam logic [1:0] OUT_GROUP   = 2'd0;
    localparam logic [1:0] OUT_SUMMARY = 2'd1;
    localparam logic [1:0] OUT_ERROR   = 2'd2;

    typedef struct packed {
        logic       capture;
        logic       seed_init;
        logic       seed_dec;
        logic       mix_en;
        logic [2:0] mix_sel;
        logic       check;
        logic       acc_obs;
        logic       close_grp;
        logic       close_last;
        logic       advance;
        logic       load_out;
        logic [1:0] out_sel;
        logic       out_last;
    } igc_cmd_t;

    typedef struct packed {
        logic       seed_done;
        logic [1:0] err;
        logic       newgrp;
        logic       last;
        logic       ids;
        logic       emit_groups;
    } igc_stat_t;

    typedef struct packed {
        logic [1:0]  record_kind;
        logic [31:0] group_begin;
        logic [31:0] group_end;
        logic [31:0] group_len;
        logic [31:0] total_observations;
        logic [30:0] widest_window;
        logic [31:0] group_total;
        logic [31:0] most_per_group;
        logic [63:0] batch_hash;
        logic [1:0]  error_code;
        logic        last_result;
    } igc_result_t;

    function automatic logic [63:0] hash_mix(input logic [63:0] h, input logic [63:0] v);
        hash_mix = h ^ (v + GOLDEN + (h << 6) + (h >> 2));
    endfunction

endpackage

### src/igc_datapath.sv
module igc_datapath #(
    parameter int COUNT_WIDTH = 32,
    parameter int MAX_INPUTS  = 255
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_we,
    input  logic [2:0]          cfg_index,
    input  logic [31:0]         cfg_data,
    input  logic signed [31:0]  s_interval_start,
    input  logic signed [31:0]  s_interval_end,
    input  logic signed [31:0]  s_product_id,
    input  logic                s_last_row,
    input  igc_pkg::igc_cmd_t   cmd,
    output igc_pkg::igc_stat_t  stat,
    output igc_pkg::igc_result_t result
);
    import igc_pkg::*;

    localparam int SEED_W = $clog2(MAX_INPUTS + 1);
    localparam int SUM_W  = ((COUNT_WIDTH > 31) ? COUNT_WIDTH : 31) + 1;
    localparam int CW1    = COUNT_WIDTH + 1;
    localparam logic [SUM_W-1:0] LIM_W = SUM_W'({COUNT_WIDTH{1'b1}});

    logic [31:0] row_count_reg;
    logic [7:0]  columns_reg;
    logic [30:0] input_length_reg;
    logic        ids_reg;
    logic        emit_reg;

    logic signed [31:0] start_reg;
    logic signed [31:0] end_reg;
    logic signed [31:0] prod_reg;
    logic               last_reg;

    logic [63:0]            sig_reg;
    logic [SEED_W-1:0]      seed_cnt_reg;
    logic [COUNT_WIDTH-1:0] row_index_reg;
    logic [30:0]            prev_reg;
    logic [COUNT_WIDTH-1:0] gfirst_reg;
    logic [COUNT_WIDTH-1:0] gsum_reg;
    logic [COUNT_WIDTH-1:0] obs_reg;
    logic [30:0]            wmax_reg;
    logic [COUNT_WIDTH-1:0] gcount_reg;
    logic [COUNT_WIDTH-1:0] grows_reg;

    logic [1:0]  err_reg;
    logic [30:0] n_reg;
    logic        newgrp_reg;

    igc_result_t result_reg;
    igc_result_t result_next;

    // mixing
    logic [63:0] mix_v;
    logic [63:0] mix_h;
    logic [63:0] mix_out;

    always_comb begin
        case (cmd.mix_sel)
            MIX_ROWS:    mix_v = 64'(row_count_reg);
            MIX_INPUTS:  mix_v = 64'(columns_reg);
            MIX_IDS:     mix_v = 64'(ids_reg);
            MIX_LENGTH:  mix_v = 64'(input_length_reg);
            MIX_START:   mix_v = 64'(unsigned'(start_reg));
            MIX_END:     mix_v = 64'(unsigned'(end_reg));
            MIX_PRODUCT: mix_v = 64'(unsigned'(prod_reg));
            default:     mix_v = '0;
        endcase
        mix_h   = cmd.seed_init ? SEED_TAG : sig_reg;
        mix_out = hash_mix(mix_h, mix_v);
    end

    // row checks
    logic             row_nz;
    logic             bad_iv;
    logic             bad_id;
    logic [31:0]      diff_c;
    logic [30:0]      n_c;
    logic             newgrp_c;
    logic [SUM_W-1:0] obs_c;
    logic [SUM_W-1:0] gs_c;
    logic [CW1-1:0]   gc_c;
    logic             ovf_c;
    logic [1:0]       err_c;
    logic [COUNT_WIDTH-1:0] rows_in;
    logic [SEED_W-1:0] seed_load;

    always_comb begin
        row_nz   = row_index_reg != '0;
        bad_iv   = start_reg[31] || (end_reg < start_reg) ||
                   (end_reg > $signed({1'b0, input_length_reg}));
        bad_id   = ids_reg && (prod_reg[31] || (row_nz && (prod_reg[30:0] < prev_reg)));
        diff_c   = end_reg - start_reg;
        n_c      = diff_c[30:0];
        newgrp_c = row_nz && (!ids_reg || (prod_reg != $signed({1'b0, prev_reg})));
        obs_c    = SUM_W'(obs_reg) + SUM_W'(n_c);
        gs_c     = newgrp_c ? SUM_W'(n_c) : (SUM_W'(gsum_reg) + SUM_W'(n_c));
        gc_c     = CW1'(gcount_reg) + CW1'(newgrp_c) + CW1'(last_reg);
        ovf_c    = (obs_c > LIM_W) || (gs_c > LIM_W) || (&row_index_reg) || gc_c[COUNT_WIDTH];
        if (bad_iv) begin
            err_c = ERR_INTERVAL;
        end else if (bad_id) begin
            err_c = ERR_PRODUCT;
        end else if (ovf_c) begin
            err_c = ERR_OVERFLOW;
        end else begin
            err_c = ERR_NONE;
        end
        rows_in = row_index_reg - gfirst_reg;
        if (32'(columns_reg) > 32'(MAX_INPUTS)) begin
            seed_load = SEED_W'(MAX_INPUTS);
        end else begin
            seed_load = SEED_W'(columns_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_count_reg    <= '0;
            columns_reg      <= '0;
            input_length_reg <= '0;
            ids_reg          <= 1'b0;
            emit_reg         <= 1'b1;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_ROW_COUNT:    row_count_reg    <= cfg_data;
                CFG_COLUMNS:      columns_reg      <= cfg_data[7:0];
                CFG_INPUT_LENGTH: input_length_reg <= cfg_data[30:0];
                CFG_USE_IDS:      ids_reg          <= cfg_data[0];
                CFG_EMIT_GROUPS:  emit_reg         <= cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            start_reg <= s_interval_start;
            end_reg   <= s_interval_end;
            prod_reg  <= s_product_id;
            last_reg  <= s_last_row;
        end
        if (cmd.check) begin
            err_reg    <= err_c;
            n_reg      <= n_c;
            newgrp_reg <= newgrp_c;
        end
        if (cmd.seed_init) begin
            seed_cnt_reg <= seed_load;
        end else if (cmd.seed_dec) begin
            seed_cnt_reg <= seed_cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sig_reg       <= '0;
            row_index_reg <= '0;
            prev_reg      <= '0;
            gfirst_reg    <= '0;
            gsum_reg      <= '0;
            obs_reg       <= '0;
            wmax_reg      <= '0;
            gcount_reg    <= '0;
            grows_reg     <= '0;
        end else begin
            if (cmd.mix_en) begin
                sig_reg <= mix_out;
            end
            if (cmd.seed_init) begin
                row_index_reg <= '0;
                prev_reg      <= '0;
                gfirst_reg    <= '0;
                gsum_reg      <= '0;
                obs_reg       <= '0;
                wmax_reg      <= '0;
                gcount_reg    <= '0;
                grows_reg     <= '0;
            end
            if (cmd.acc_obs) begin
                obs_reg <= obs_reg + COUNT_WIDTH'(n_reg);
                if (n_reg > wmax_reg) begin
                    wmax_reg <= n_reg;
                end
            end
            if (cmd.close_grp || cmd.close_last) begin
                gcount_reg <= gcount_reg + 1'b1;
                if (rows_in > grows_reg) begin
                    grows_reg <= rows_in;
                end
            end
            if (cmd.close_grp) begin
                gfirst_reg <= row_index_reg;
                gsum_reg   <= '0;
            end
            if (cmd.advance) begin
                gsum_reg      <= gsum_reg + COUNT_WIDTH'(n_reg);
                row_index_reg <= row_index_reg + 1'b1;
                if (ids_reg) begin
                    prev_reg <= prod_reg[30:0];
                end
            end
        end
    end

    always_comb begin
        result_next = '0;
        result_next.last_result = cmd.out_last;
        case (cmd.out_sel)
            OUT_GROUP: begin
                result_next.record_kind = KIND_GROUP;
                result_next.group_begin = 32'(gfirst_reg);
                result_next.group_end   = 32'(row_index_reg);
                result_next.group_len   = 32'(gsum_reg);
            end
            OUT_SUMMARY: begin
                result_next.record_kind        = KIND_SUMMARY;
                result_next.total_observations = 32'(obs_reg);
                result_next.widest_window      = wmax_reg;
                result_next.group_total        = 32'(gcount_reg);
                result_next.most_per_group     = 32'(grows_reg);
                result_next.batch_hash         = sig_reg;
            end
            default: begin
                result_next.record_kind = KIND_ERROR;
                result_next.error_code  = err_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            result_reg <= result_next;
        end
    end

    assign result = result_reg;

    always_comb begin
        stat.seed_done   = seed_cnt_reg == '0;
        stat.err         = err_reg;
        stat.newgrp      = newgrp_reg;
        stat.last        = last_reg;
        stat.ids         = ids_reg;
        stat.emit_groups = emit_reg;
    end

endmodule

### src/igc_ctrl.sv
module igc_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    output logic               m_valid,
    input  logic               m_ready,
    input  igc_pkg::igc_stat_t stat,
    output igc_pkg::igc_cmd_t  cmd
);
    import igc_pkg::*;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_SEED0 = 4'd1;
    localparam logic [3:0] S_SEED1 = 4'd2;
    localparam logic [3:0] S_SEED2 = 4'd3;
    localparam logic [3:0] S_SEEDL = 4'd4;
    localparam logic [3:0] S_CHECK = 4'd5;
    localparam logic [3:0] S_JUDGE = 4'd6;
    localparam logic [3:0] S_MIXE  = 4'd7;
    localparam logic [3:0] S_MIXP  = 4'd8;
    localparam logic [3:0] S_GROUP = 4'd9;
    localparam logic [3:0] S_ADV   = 4'd10;
    localparam logic [3:0] S_LASTG = 4'd11;
    localparam logic [3:0] S_SUMM  = 4'd12;

    logic [3:0] state_reg, state_next;
    logic       open_reg, open_next;
    logic       errseen_reg, errseen_next;
    logic       mvalid_reg, mvalid_next;
    logic       out_free;

    assign out_free = !mvalid_reg || m_ready;
    assign s_ready  = state_reg == S_IDLE;
    assign m_valid  = mvalid_reg;

    always_comb begin
        state_next   = state_reg;
        open_next    = open_reg;
        errseen_next = errseen_reg;
        cmd          = '0;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    state_next  = open_reg ? S_CHECK : S_SEED0;
                end
            end
            S_SEED0: begin
                cmd.seed_init = 1'b1;
                cmd.mix_en    = 1'b1;
                cmd.mix_sel   = MIX_ROWS;
                open_next     = 1'b1;
                errseen_next  = 1'b0;
                state_next    = S_SEED1;
            end
            S_SEED1: begin
                cmd.mix_en  = 1'b1;
                cmd.mix_sel = MIX_INPUTS;
                state_next  = S_SEED2;
            end
            S_SEED2: begin
                cmd.mix_en  = 1'b1;
                cmd.mix_sel = MIX_IDS;
                state_next  = S_SEEDL;
            end
            S_SEEDL: begin
                if (stat.seed_done) begin
                    state_next = S_CHECK;
                end else begin
                    cmd.mix_en   = 1'b1;
                    cmd.mix_sel  = MIX_LENGTH;
                    cmd.seed_dec = 1'b1;
                end
            end
            S_CHECK: begin
                if (errseen_reg) begin
                    if (stat.last) begin
                        open_next    = 1'b0;
                        errseen_next = 1'b0;
                    end
                    state_next = S_IDLE;
                end else begin
                    cmd.check  = 1'b1;
                    state_next = S_JUDGE;
                end
            end
            S_JUDGE: begin
                if (stat.err != ERR_NONE) begin
                    if (out_free) begin
                        cmd.load_out = 1'b1;
                        cmd.out_sel  = OUT_ERROR;
                        cmd.out_last = 1'b1;
                        errseen_next = !stat.last;
                        open_next    = !stat.last;
                        state_next   = S_IDLE;
                    end
                end else begin
                    cmd.mix_en  = 1'b1;
                    cmd.mix_sel = MIX_START;
                    cmd.acc_obs = 1'b1;
                    state_next  = S_MIXE;
                end
            end
            S_MIXE: begin
                cmd.mix_en  = 1'b1;
                cmd.mix_sel = MIX_END;
                state_next  = stat.ids ? S_MIXP : S_GROUP;
            end
            S_MIXP: begin
                cmd.mix_en  = 1'b1;
                cmd.mix_sel = MIX_PRODUCT;
                state_next  = S_GROUP;
            end
            S_GROUP: begin
                if (!stat.newgrp) begin
                    state_next = S_ADV;
                end else if (!stat.emit_groups) begin
                    cmd.close_grp = 1'b1;
                    state_next    = S_ADV;
                end else if (out_free) begin
                    cmd.close_grp = 1'b1;
                    cmd.load_out  = 1'b1;
                    cmd.out_sel   = OUT_GROUP;
                    cmd.out_last  = !stat.last;
                    state_next    = S_ADV;
                end
            end
            S_ADV: begin
                cmd.advance = 1'b1;
                state_next  = stat.last ? S_LASTG : S_IDLE;
            end
            S_LASTG: begin
                if (!stat.emit_groups) begin
                    cmd.close_last = 1'b1;
                    state_next     = S_SUMM;
                end else if (out_free) begin
                    cmd.close_last = 1'b1;
                    cmd.load_out   = 1'b1;
                    cmd.out_sel    = OUT_GROUP;
                    state_next     = S_SUMM;
                end
            end
            S_SUMM: begin
                if (out_free) begin
                    cmd.load_out = 1'b1;
                    cmd.out_sel  = OUT_SUMMARY;
                    cmd.out_last = 1'b1;
                    open_next    = 1'b0;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
        mvalid_next = cmd.load_out ? 1'b1 : (mvalid_reg && !m_ready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            open_reg    <= 1'b0;
            errseen_reg <= 1'b0;
            mvalid_reg  <= 1'b0;
        end else begin
            state_reg   <= state_next;
            open_reg    <= open_next;
            errseen_reg <= errseen_next;
            mvalid_reg  <= mvalid_next;
        end
    end

`ifndef SYNTH
    a_load_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |-> (!mvalid_reg || m_ready))
        else $error("result register overwritten");
    a_seed_on_closed: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && !open_reg) |=> (state_reg == S_SEED0))
        else $error("closed batch not seeded");
    a_err_in_batch: assert property (@(posedge aclk) disable iff (!aresetn)
        errseen_reg |-> open_reg)
        else $error("error flag outside batch");
    a_summary_closes: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.load_out && (cmd.out_sel == OUT_SUMMARY)) |=> !open_reg)
        else $error("summary left batch open");
`endif

endmodule

### src/interval_geometry_checker.sv
// A row opening a new group emits the prior group's record if emit_groups is set; an erring
//   row gives an error record and later rows of that batch are dropped; a last row also emits
//   the final group record and the summary. A batch's first row seeds the signature from row
//   count, column count, ids flag and the input length (once per column, up to MAX_INPUTS).
//   Rows go one at a time through the single 64-bit hash-mix unit, one mix a cycle.
// Reset: synchronous active-low aresetn clears the batch, totals and signature;
//   emit_groups resets to 1, other configuration registers to 0.
module interval_geometry_checker #(
    parameter int COUNT_WIDTH = igc_pkg::COUNT_WIDTH_DEF,
    parameter int MAX_INPUTS  = igc_pkg::MAX_INPUTS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [31:0] s_interval_start,
    input  logic signed [31:0] s_interval_end,
    input  logic signed [31:0] s_product_id,
    input  logic               s_last_row,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [1:0]         m_record_kind,
    output logic [31:0]        m_group_begin,
    output logic [31:0]        m_group_end,
    output logic [31:0]        m_group_len,
    output logic [31:0]        m_total_observations,
    output logic [30:0]        m_widest_window,
    output logic [31:0]        m_group_total,
    output logic [31:0]        m_most_per_group,
    output logic [63:0]        m_batch_hash,
    output logic [1:0]         m_error_code,
    output logic               m_last_result
);
    import igc_pkg::*;

    igc_cmd_t    cmd;
    igc_stat_t   stat;
    igc_result_t result;

    assign cfg_ready = 1'b1;

    igc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    igc_datapath #(
        .COUNT_WIDTH (COUNT_WIDTH),
        .MAX_INPUTS  (MAX_INPUTS)
    ) u_datapath (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_we           (cfg_valid && cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .s_interval_start (s_interval_start),
        .s_interval_end   (s_interval_end),
        .s_product_id     (s_product_id),
        .s_last_row       (s_last_row),
        .cmd              (cmd),
        .stat             (stat),
        .result           (result)
    );

    assign m_record_kind        = result.record_kind;
    assign m_group_begin        = result.group_begin;
    assign m_group_end          = result.group_end;
    assign m_group_len          = result.group_len;
    assign m_total_observations = result.total_observations;
    assign m_widest_window      = result.widest_window;
    assign m_group_total        = result.group_total;
    assign m_most_per_group     = result.most_per_group;
    assign m_batch_hash         = result.batch_hash;
    assign m_error_code         = result.error_code;
    assign m_last_result        = result.last_result;

endmodule
